/* rtl/msslf_pkg.sv */
// Shared constants for the multi-stack shared free list block.
package msslf_pkg;

   localparam int DATA_W = 32;

   localparam logic OP_PUSH = 1'b0;
   localparam logic OP_POP  = 1'b1;

   localparam logic [1:0] ST_DONE      = 2'd0;
   localparam logic [1:0] ST_OVERFLOW  = 2'd1;
   localparam logic [1:0] ST_UNDERFLOW = 2'd2;

   localparam logic [DATA_W-1:0] UNDERFLOW_VALUE = 32'h7FFF_FFFF;

endpackage

/* rtl/msslf_slot_mem.sv */
// Slot memory: data word and link per slot, one write and one registered read port.
module msslf_slot_mem #(
   parameter int SLOTS = 64,
   parameter int AW    = 6,
   parameter int IDX_W = 7
) (
   input  logic                        clock,
   input  logic                        wr_en,
   input  logic [AW-1:0]               wr_addr,
   input  logic [msslf_pkg::DATA_W-1:0] wr_data,
   input  logic [IDX_W-1:0]            wr_link,
   input  logic                        rd_en,
   input  logic [AW-1:0]               rd_addr,
   output logic [msslf_pkg::DATA_W-1:0] rd_data,
   output logic [IDX_W-1:0]            rd_link
);

   logic [msslf_pkg::DATA_W+IDX_W-1:0] mem_ff [SLOTS];
   logic [msslf_pkg::DATA_W+IDX_W-1:0] q_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= {wr_data, wr_link};
      end
      if (rd_en) begin
         q_ff <= mem_ff[rd_addr];
      end
   end

   assign rd_data = q_ff[msslf_pkg::DATA_W+IDX_W-1:IDX_W];
   assign rd_link = q_ff[IDX_W-1:0];

endmodule

/* rtl/msslf_top_mem.sv */
// Stack-top memory with per-entry valid bits; an unwritten top reads as null.
module msslf_top_mem #(
   parameter int NUM_STACKS = 4,
   parameter int SID_W      = 2,
   parameter int IDX_W      = 7,
   parameter int SLOTS      = 64
) (
   input  logic             clock,
   input  logic             reset,
   input  logic             wr_en,
   input  logic [SID_W-1:0] wr_addr,
   input  logic [IDX_W-1:0] wr_data,
   input  logic             rd_en,
   input  logic [SID_W-1:0] rd_addr,
   output logic [IDX_W-1:0] rd_top
);

   localparam logic [IDX_W-1:0] NIL = IDX_W'(SLOTS);

   logic [IDX_W-1:0]      mem_ff [NUM_STACKS];
   logic [NUM_STACKS-1:0] vld_ff;
   logic [IDX_W-1:0]      q_ff;
   logic                  q_vld_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         q_ff <= mem_ff[rd_addr];
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         vld_ff   <= '0;
         q_vld_ff <= 1'b0;
      end else begin
         if (wr_en) begin
            vld_ff[wr_addr] <= 1'b1;
         end
         if (rd_en) begin
            q_vld_ff <= vld_ff[rd_addr];
         end
      end
   end

   assign rd_top = q_vld_ff ? q_ff : NIL;

endmodule

/* rtl/multi_stack_shared_free_list.sv */
// Several LIFO stacks sharing one slot store, unused slots chained in a free list.
// Push: stack-top and free-slot reads in parallel; the result is registered from S_RD.
// Pop: stack-top read, then slot read of the top; an empty stack answers from S_RD.
// One item at a time; the next transfer is taken the cycle after the result is registered.
// Reset: free list holds all slots in order, every stack empty, usable at once (no clear pass).
module multi_stack_shared_free_list #(
   parameter int NUM_STACKS = 4,
   parameter int SLOTS      = 64
) (
   input  logic               clock,
   input  logic               reset,
   input  logic               req_valid,
   output logic               req_stall,
   input  logic               req_operation,
   input  logic [1:0]         req_stack_id,
   input  logic signed [31:0] req_push_value,
   output logic               rsp_valid,
   input  logic               rsp_stall,
   output logic [1:0]         rsp_status,
   output logic signed [31:0] rsp_popped_value,
   output logic               rsp_store_full,
   output logic               rsp_stack_empty
);

   localparam int AW    = (SLOTS > 1) ? $clog2(SLOTS) : 1;
   localparam int IDX_W = $clog2(SLOTS + 1);
   localparam int SID_W = (NUM_STACKS > 1) ? $clog2(NUM_STACKS) : 1;
   localparam logic [IDX_W-1:0] NIL = IDX_W'(SLOTS);

   localparam logic [1:0] S_IDLE = 2'd0;
   localparam logic [1:0] S_RD   = 2'd1;
   localparam logic [1:0] S_POP  = 2'd2;

   logic [1:0]                    state_ff, state_in;
   logic                          op_ff;
   logic                          sid_ok_ff;
   logic [SID_W-1:0]              sid_ff;
   logic [msslf_pkg::DATA_W-1:0]  val_ff;
   logic [IDX_W-1:0]              free_head_ff, free_head_in;
   logic [IDX_W-1:0]              hwm_ff, hwm_in;

   logic                          rsp_valid_ff, rsp_valid_in;
   logic [1:0]                    rsp_status_ff;
   logic [msslf_pkg::DATA_W-1:0]  rsp_value_ff;
   logic                          rsp_full_ff;
   logic                          rsp_empty_ff;

   logic                          accept;
   logic                          out_free;
   logic                          commit;
   logic [1:0]                    res_status;
   logic [msslf_pkg::DATA_W-1:0]  res_value;
   logic                          res_full;
   logic                          res_empty;

   logic                          top_wr_en;
   logic [IDX_W-1:0]              top_wr_data;
   logic [IDX_W-1:0]              top_q;
   logic                          slot_wr_en;
   logic [AW-1:0]                 slot_wr_addr;
   logic [msslf_pkg::DATA_W-1:0]  slot_wr_data;
   logic [IDX_W-1:0]              slot_wr_link;
   logic                          slot_rd_en;
   logic [AW-1:0]                 slot_rd_addr;
   logic [msslf_pkg::DATA_W-1:0]  slot_q_data;
   logic [IDX_W-1:0]              slot_q_link;

   logic                          free_nil;
   logic                          top_nil;
   logic                          fresh;
   logic [IDX_W-1:0]              next_free;

   assign accept   = req_valid && (state_ff == S_IDLE);
   assign out_free = !rsp_valid_ff || !rsp_stall;
   assign free_nil = free_head_ff >= NIL;
   assign top_nil  = top_q >= NIL;
   // Slots at or above the high-water mark were never written: link is the next index.
   assign fresh     = free_head_ff == hwm_ff;
   assign next_free = fresh ? (hwm_ff + IDX_W'(1)) : slot_q_link;

   msslf_top_mem #(
      .NUM_STACKS (NUM_STACKS),
      .SID_W      (SID_W),
      .IDX_W      (IDX_W),
      .SLOTS      (SLOTS)
   ) u_top_mem (
      .clock   (clock),
      .reset   (reset),
      .wr_en   (top_wr_en),
      .wr_addr (sid_ff),
      .wr_data (top_wr_data),
      .rd_en   (accept),
      .rd_addr (SID_W'(req_stack_id)),
      .rd_top  (top_q)
   );

   msslf_slot_mem #(
      .SLOTS (SLOTS),
      .AW    (AW),
      .IDX_W (IDX_W)
   ) u_slot_mem (
      .clock   (clock),
      .wr_en   (slot_wr_en),
      .wr_addr (slot_wr_addr),
      .wr_data (slot_wr_data),
      .wr_link (slot_wr_link),
      .rd_en   (slot_rd_en),
      .rd_addr (slot_rd_addr),
      .rd_data (slot_q_data),
      .rd_link (slot_q_link)
   );

   always_comb begin
      state_in     = state_ff;
      free_head_in = free_head_ff;
      hwm_in       = hwm_ff;
      top_wr_en    = 1'b0;
      top_wr_data  = free_head_ff;
      slot_wr_en   = 1'b0;
      slot_wr_addr = free_head_ff[AW-1:0];
      slot_wr_data = val_ff;
      slot_wr_link = top_q;
      slot_rd_en   = 1'b0;
      slot_rd_addr = free_head_ff[AW-1:0];
      commit       = 1'b0;
      res_status   = msslf_pkg::ST_DONE;
      res_value    = '0;
      res_full     = free_nil;
      res_empty    = !sid_ok_ff || top_nil;
      unique case (state_ff)
         S_IDLE: begin
            if (accept) begin
               slot_rd_en = 1'b1;
               state_in   = S_RD;
            end
         end
         S_RD: begin
            if (op_ff == msslf_pkg::OP_PUSH) begin
               if (!sid_ok_ff || free_nil) begin
                  res_status = msslf_pkg::ST_OVERFLOW;
               end else begin
                  res_full  = next_free >= NIL;
                  res_empty = 1'b0;
               end
               if (out_free) begin
                  commit   = 1'b1;
                  state_in = S_IDLE;
                  if (sid_ok_ff && !free_nil) begin
                     // Link new slot above the old top and make it the top.
                     slot_wr_en   = 1'b1;
                     top_wr_en    = 1'b1;
                     free_head_in = next_free;
                     if (fresh) begin
                        hwm_in = hwm_ff + IDX_W'(1);
                     end
                  end
               end
            end else if (!sid_ok_ff || top_nil) begin
               res_status = msslf_pkg::ST_UNDERFLOW;
               res_value  = msslf_pkg::UNDERFLOW_VALUE;
               res_empty  = 1'b1;
               if (out_free) begin
                  commit   = 1'b1;
                  state_in = S_IDLE;
               end
            end else begin
               slot_rd_en   = 1'b1;
               slot_rd_addr = top_q[AW-1:0];
               state_in     = S_POP;
            end
         end
         S_POP: begin
            res_value = slot_q_data;
            res_full  = 1'b0;
            res_empty = slot_q_link >= NIL;
            if (out_free) begin
               commit = 1'b1;
               state_in = S_IDLE;
               // Unlink the top slot and push it onto the free list.
               top_wr_en    = 1'b1;
               top_wr_data  = slot_q_link;
               slot_wr_en   = 1'b1;
               slot_wr_addr = top_q[AW-1:0];
               slot_wr_data = slot_q_data;
               slot_wr_link = free_head_ff;
               free_head_in = top_q;
            end
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

   always_comb begin
      rsp_valid_in = rsp_valid_ff;
      if (commit) begin
         rsp_valid_in = 1'b1;
      end else if (!rsp_stall) begin
         rsp_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_IDLE;
         free_head_ff <= '0;
         hwm_ff       <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         free_head_ff <= free_head_in;
         hwm_ff       <= hwm_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (accept) begin
         op_ff     <= req_operation;
         sid_ff    <= SID_W'(req_stack_id);
         sid_ok_ff <= 32'(req_stack_id) < NUM_STACKS;
         val_ff    <= req_push_value;
      end
      if (commit) begin
         rsp_status_ff <= res_status;
         rsp_value_ff  <= res_value;
         rsp_full_ff   <= res_full;
         rsp_empty_ff  <= res_empty;
      end
   end

   assign req_stall        = state_ff != S_IDLE;
   assign rsp_valid        = rsp_valid_ff;
   assign rsp_status       = rsp_status_ff;
   assign rsp_popped_value = rsp_value_ff;
   assign rsp_store_full   = rsp_full_ff;
   assign rsp_stack_empty  = rsp_empty_ff;

endmodule

/* test/multi_stack_shared_free_list_tb.sv */
// Self-checking testbench for the multi-stack shared free list: directed and random push/pop traffic.
module multi_stack_shared_free_list_tb;

   localparam int CLK_PERIOD  = 10;
   localparam int NSTK        = 4;
   localparam int NSLOT       = 64;
   localparam int RANDOM_OPS  = 1200;
   localparam int CYCLE_LIMIT = 400000;
   localparam logic [6:0] NULL_SLOT = 7'(NSLOT);

   typedef struct packed {
      logic               operation;
      logic [1:0]         stack_id;
      logic signed [31:0] push_value;
   } stack_op_type;

   typedef struct packed {
      logic [1:0]         status;
      logic signed [31:0] popped_value;
      logic               store_full;
      logic               stack_empty;
   } stack_result_type;

   logic               clock = 1'b0;
   logic               reset = 1'b1;
   logic               req_valid = 1'b0;
   logic               req_stall;
   logic               req_operation = msslf_pkg::OP_PUSH;
   logic [1:0]         req_stack_id = 2'd0;
   logic signed [31:0] req_push_value = '0;
   logic               rsp_valid;
   logic               rsp_stall = 1'b0;
   logic [1:0]         rsp_status;
   logic signed [31:0] rsp_popped_value;
   logic               rsp_store_full;
   logic               rsp_stack_empty;

   // golden copy of the slot store
   logic signed [31:0] slot_value [NSLOT];
   logic [6:0]         slot_next [NSLOT];
   logic [6:0]         top_of [NSTK];
   logic [6:0]         free_first;

   stack_op_type     pending_ops [$];
   stack_result_type expected_results [$];
   stack_op_type     cur_op;
   int            queued_count = 0;
   int            accepted_count = 0;
   int            error_count = 0;
   int            cycle_count = 0;
   int            req_gap = 0;
   int            rsp_hold = 0;
   bit            calm = 1'b0;

   multi_stack_shared_free_list #(
      .NUM_STACKS(NSTK),
      .SLOTS     (NSLOT)
   ) i_dut (
      .clock           (clock),
      .reset           (reset),
      .req_valid       (req_valid),
      .req_stall       (req_stall),
      .req_operation   (req_operation),
      .req_stack_id    (req_stack_id),
      .req_push_value  (req_push_value),
      .rsp_valid       (rsp_valid),
      .rsp_stall       (rsp_stall),
      .rsp_status      (rsp_status),
      .rsp_popped_value(rsp_popped_value),
      .rsp_store_full  (rsp_store_full),
      .rsp_stack_empty (rsp_stack_empty)
   );

   always #(CLK_PERIOD / 2) clock = ~clock;

   function automatic void clear_stacks();
      for (int i = 0; i < NSLOT; i++) begin
         slot_value[i] = '0;
         slot_next[i]  = 7'(i + 1);
      end
      for (int s = 0; s < NSTK; s++) top_of[s] = NULL_SLOT;
      free_first = 7'd0;
   endfunction

   // apply one transfer to the golden store and return what the block must answer
   function automatic stack_result_type apply_stack_op(stack_op_type op);
      stack_result_type r;
      logic [6:0]       slot;
      r.status       = msslf_pkg::ST_DONE;
      r.popped_value = '0;
      if (op.operation == msslf_pkg::OP_PUSH) begin
         if (free_first >= NULL_SLOT) begin
            r.status = msslf_pkg::ST_OVERFLOW;
         end else begin
            slot                   = free_first;
            free_first             = slot_next[slot[5:0]];
            slot_next[slot[5:0]]   = top_of[op.stack_id];
            top_of[op.stack_id]    = slot;
            slot_value[slot[5:0]]  = op.push_value;
         end
      end else begin
         if (top_of[op.stack_id] >= NULL_SLOT) begin
            r.status       = msslf_pkg::ST_UNDERFLOW;
            r.popped_value = msslf_pkg::UNDERFLOW_VALUE;
         end else begin
            slot                 = top_of[op.stack_id];
            top_of[op.stack_id]  = slot_next[slot[5:0]];
            slot_next[slot[5:0]] = free_first;
            free_first           = slot;
            r.popped_value       = slot_value[slot[5:0]];
         end
      end
      r.store_full  = (free_first >= NULL_SLOT);
      r.stack_empty = (top_of[op.stack_id] >= NULL_SLOT);
      return r;
   endfunction

   function automatic int draw_wait();
      if (calm || $urandom_range(0, 2) != 0) return 0;
      return $urandom_range(0, 18);
   endfunction

   function automatic logic signed [31:0] pick_value();
      case ($urandom_range(0, 7))
         0: return 32'sh8000_0000;
         1: return 32'sh7FFF_FFFF;
         2: return -32'sd1;
         3: return 32'sd0;
         default: return $urandom;
      endcase
   endfunction

   task automatic queue_op(logic operation, logic [1:0] stack_id, logic signed [31:0] value);
      stack_op_type op;
      op.operation  = operation;
      op.stack_id   = stack_id;
      op.push_value = value;
      pending_ops.push_back(op);
      queued_count++;
   endtask

   task automatic wait_drained();
      while (accepted_count < queued_count || expected_results.size() != 0)
         @(posedge clock);
   endtask

   task automatic report_mismatch(string what, longint got, longint want);
      $display("mismatch at cycle %0d: %s got %0h want %0h", cycle_count, what, got, want);
      error_count++;
   endtask

   // driver
   always @(posedge clock) begin
      if (reset) begin
         req_valid <= 1'b0;
         req_gap   = 0;
      end else begin
         if (req_valid && !req_stall) begin
            expected_results.push_back(apply_stack_op(cur_op));
            accepted_count++;
         end
         if (!req_valid || !req_stall) begin
            if (req_gap > 0) begin
               req_gap--;
               req_valid <= 1'b0;
            end else if (pending_ops.size() != 0) begin
               cur_op = pending_ops.pop_front();
               req_operation  <= cur_op.operation;
               req_stack_id   <= cur_op.stack_id;
               req_push_value <= cur_op.push_value;
               req_valid      <= 1'b1;
               req_gap = draw_wait();
            end else begin
               req_valid <= 1'b0;
            end
         end
      end
   end

   // monitor
   always @(posedge clock) begin
      stack_result_type want;
      if (reset) begin
         rsp_stall <= 1'b0;
         rsp_hold  = 0;
      end else begin
         if (rsp_valid && !rsp_stall) begin
            if (expected_results.size() == 0) begin
               report_mismatch("unexpected transfer, status", rsp_status, 0);
            end else begin
               want = expected_results.pop_front();
               if (rsp_status !== want.status)
                  report_mismatch("status", rsp_status, want.status);
               if (rsp_popped_value !== want.popped_value)
                  report_mismatch("popped_value", rsp_popped_value, want.popped_value);
               if (rsp_store_full !== want.store_full)
                  report_mismatch("store_full", rsp_store_full, want.store_full);
               if (rsp_stack_empty !== want.stack_empty)
                  report_mismatch("stack_empty", rsp_stack_empty, want.stack_empty);
            end
            rsp_hold = draw_wait();
         end else if (rsp_valid && rsp_hold > 0) begin
            rsp_hold--;
         end
         rsp_stall <= (rsp_hold > 0);
      end
   end

   always @(posedge clock) begin
      cycle_count <= cycle_count + 1;
      if (cycle_count >= CYCLE_LIMIT) begin
         $display("FAIL");
         $finish;
      end
   end

   initial begin
      int          phase_len;
      int          push_pct;
      int          focus;
      logic [1:0]  sid;
      clear_stacks();
      repeat (3) @(posedge clock);
      reset <= 1'b0;

      // directed: empty pops, extreme values on every stack, LIFO order, drain to empty
      queue_op(msslf_pkg::OP_POP,  2'd0, 32'sd5);
      queue_op(msslf_pkg::OP_PUSH, 2'd0, 32'sh8000_0000);
      queue_op(msslf_pkg::OP_PUSH, 2'd1, 32'sh7FFF_FFFF);
      queue_op(msslf_pkg::OP_PUSH, 2'd2, 32'sd0);
      queue_op(msslf_pkg::OP_PUSH, 2'd3, -32'sd1);
      queue_op(msslf_pkg::OP_PUSH, 2'd0, 32'sh5555_5555);
      queue_op(msslf_pkg::OP_PUSH, 2'd3, 32'shAAAA_AAAA);
      queue_op(msslf_pkg::OP_POP,  2'd0, 32'sh7FFF_FFFF);
      queue_op(msslf_pkg::OP_POP,  2'd0, 32'sd0);
      queue_op(msslf_pkg::OP_POP,  2'd0, 32'sd0);
      queue_op(msslf_pkg::OP_POP,  2'd1, 32'sd0);
      queue_op(msslf_pkg::OP_POP,  2'd2, 32'sd0);
      queue_op(msslf_pkg::OP_POP,  2'd3, 32'sd0);
      queue_op(msslf_pkg::OP_POP,  2'd3, 32'sd0);
      queue_op(msslf_pkg::OP_POP,  2'd3, 32'sd0);
      queue_op(msslf_pkg::OP_POP,  2'd1, -32'sd1);
      queue_op(msslf_pkg::OP_POP,  2'd2, 32'sd0);
      queue_op(msslf_pkg::OP_PUSH, 2'd1, 32'sd1);
      queue_op(msslf_pkg::OP_PUSH, 2'd1, 32'sd2);
      queue_op(msslf_pkg::OP_POP,  2'd1, 32'sd0);
      // hold the sender until every answer is back
      wait_drained();

      // random phases; the first is push-heavy to drive the store toward full
      push_pct = 92;
      while (queued_count < RANDOM_OPS + 20) begin
         phase_len = $urandom_range(60, 160);
         focus     = $urandom_range(0, NSTK - 1);
         calm      = ($urandom_range(0, 3) == 0);
         for (int n = 0; n < phase_len; n++) begin
            sid = ($urandom_range(0, 1) != 0) ? 2'(focus) : 2'($urandom_range(0, NSTK - 1));
            queue_op(($urandom_range(0, 99) < push_pct) ? msslf_pkg::OP_PUSH
                                                         : msslf_pkg::OP_POP,
                     sid, pick_value());
         end
         if ($urandom_range(0, 2) == 0) wait_drained();
         else while (pending_ops.size() > 20) @(posedge clock);
         case ($urandom_range(0, 4))
            0: push_pct = 95;
            1: push_pct = 8;
            2: push_pct = 50;
            3: push_pct = 70;
            default: push_pct = 30;
         endcase
      end
      calm = 1'b0;
      wait_drained();
      repeat (8) @(posedge clock);
      if (error_count == 0)
         $display("PASS");
      else
         $display("FAIL");
      $finish;
   end

endmodule
